/* rtl/core/fpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_pkg
// Types and constants shared by the frustum plane cull test block.
// ----------------------------------------------------------------------------
package fpc_pkg;

   // number of frustum planes, one cell each
   localparam int NUM_PLANES = 6;
   // register index width and configuration bus widths
   localparam int CSR_ADDR_BITS = 6;
   localparam int CSR_DATA_BITS = 64;
   localparam int PLANE_IDX_BITS = 3;
   // entry stage plus two stages in every cell
   localparam int LATENCY = 1 + 2 * NUM_PLANES;

   // primitive kinds
   typedef enum logic [1:0] {
      ACT_POINT  = 2'd0,
      ACT_SPHERE = 2'd1,
      ACT_BOX    = 2'd2,
      ACT_CUBE   = 2'd3
   } action_type;

   // packed plane register: a, b, c signed Q1.10, d signed Q19.8
   typedef struct packed {
      logic signed [27:0] d;
      logic signed [11:0] c;
      logic signed [11:0] b;
      logic signed [11:0] a;
   } plane_type;

   // control travelling with each transaction along the chain
   typedef struct packed {
      logic       valid;
      logic       visible;
      action_type action;
   } ctl_type;

endpackage

/* rtl/core/fpc_csr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_csr
// Plane register file behind the configuration port.
// ----------------------------------------------------------------------------
module fpc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [fpc_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [fpc_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [fpc_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                 pready,
   output fpc_pkg::plane_type                   planes [fpc_pkg::NUM_PLANES]
);
   import fpc_pkg::*;

   plane_type                 plane_ff [NUM_PLANES];
   logic [PLANE_IDX_BITS-1:0] reg_idx;
   logic                      wr_en;

   // registers sit at eight byte steps
   assign reg_idx = paddr[CSR_ADDR_BITS-1:3];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PLANES; i++) begin
            plane_ff[i] <= '0;
         end
      end else if (wr_en) begin
         for (int i = 0; i < NUM_PLANES; i++) begin
            if (reg_idx == PLANE_IDX_BITS'(i)) begin
               plane_ff[i] <= plane_type'(pwdata);
            end
         end
      end
   end

   // read back, zero beyond the last plane
   always_comb begin
      prdata = '0;
      for (int i = 0; i < NUM_PLANES; i++) begin
         if (reg_idx == PLANE_IDX_BITS'(i)) begin
            prdata = CSR_DATA_BITS'(plane_ff[i]);
         end
      end
   end

   assign planes = plane_ff;

endmodule

/* rtl/core/fpc_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_cell
// One plane of the chain: picks the farthest corner of a box or cube, forms its distance
// and clears the visible flag when the plane rejects the primitive.
// ----------------------------------------------------------------------------
module fpc_cell #(
   parameter int COORD_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  fpc_pkg::plane_type           plane,
   input  fpc_pkg::ctl_type             in_ctl,
   input  logic signed [COORD_BITS:0]   in_lo_x,
   input  logic signed [COORD_BITS:0]   in_lo_y,
   input  logic signed [COORD_BITS:0]   in_lo_z,
   input  logic signed [COORD_BITS:0]   in_hi_x,
   input  logic signed [COORD_BITS:0]   in_hi_y,
   input  logic signed [COORD_BITS:0]   in_hi_z,
   input  logic [COORD_BITS-2:0]        in_radius,
   output fpc_pkg::ctl_type             out_ctl,
   output logic signed [COORD_BITS:0]   out_lo_x,
   output logic signed [COORD_BITS:0]   out_lo_y,
   output logic signed [COORD_BITS:0]   out_lo_z,
   output logic signed [COORD_BITS:0]   out_hi_x,
   output logic signed [COORD_BITS:0]   out_hi_y,
   output logic signed [COORD_BITS:0]   out_hi_z,
   output logic [COORD_BITS-2:0]        out_radius
);
   import fpc_pkg::*;

   localparam int CW        = COORD_BITS + 1;
   localparam int PROD_BITS = CW + 12;
   localparam int BIAS_BITS = ((COORD_BITS + 10 > 38) ? COORD_BITS + 10 : 38) + 1;
   localparam int SUM_BITS  = ((PROD_BITS > BIAS_BITS) ? PROD_BITS : BIAS_BITS) + 2;

   logic                        use_corner;
   logic signed [CW-1:0]        sel_x, sel_y, sel_z;
   logic signed [PROD_BITS-1:0] prod_x_in, prod_y_in, prod_z_in;
   logic signed [PROD_BITS-1:0] prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [BIAS_BITS-1:0] bias_in, bias_ff;
   ctl_type                     ctl_a_ff, ctl_b_ff;
   logic signed [CW-1:0]        lo_x_ff, lo_y_ff, lo_z_ff, hi_x_ff, hi_y_ff, hi_z_ff;
   logic signed [CW-1:0]        lo_x_b_ff, lo_y_b_ff, lo_z_b_ff;
   logic signed [CW-1:0]        hi_x_b_ff, hi_y_b_ff, hi_z_b_ff;
   logic [COORD_BITS-2:0]       radius_ff, radius_b_ff;
   logic signed [SUM_BITS-1:0]  dist_sum;
   logic                        reject;
   ctl_type                     ctl_b_in;

   // boxes and cubes use the corner farthest along the normal
   assign use_corner = (in_ctl.action == ACT_BOX) || (in_ctl.action == ACT_CUBE);

   always_comb begin
      sel_x = in_lo_x;
      sel_y = in_lo_y;
      sel_z = in_lo_z;
      if (use_corner) begin
         if (plane.a[11] == (in_hi_x > in_lo_x)) sel_x = in_lo_x;
         else                                     sel_x = in_hi_x;
         if (plane.b[11] == (in_hi_y > in_lo_y)) sel_y = in_lo_y;
         else                                     sel_y = in_hi_y;
         if (plane.c[11] == (in_hi_z > in_lo_z)) sel_z = in_lo_z;
         else                                     sel_z = in_hi_z;
      end
   end

   // products and offset, d and radius scaled to Q.18
   assign prod_x_in = PROD_BITS'($signed(plane.a)) * PROD_BITS'(sel_x);
   assign prod_y_in = PROD_BITS'($signed(plane.b)) * PROD_BITS'(sel_y);
   assign prod_z_in = PROD_BITS'($signed(plane.c)) * PROD_BITS'(sel_z);

   always_comb begin
      bias_in = BIAS_BITS'($signed(plane.d)) <<< 10;
      if (in_ctl.action == ACT_SPHERE) begin
         bias_in = bias_in + ($signed(BIAS_BITS'({1'b0, in_radius})) <<< 10);
      end
   end

   // multiply stage
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
      end else begin
         ctl_a_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      prod_z_ff <= prod_z_in;
      bias_ff   <= bias_in;
      lo_x_ff   <= in_lo_x;
      lo_y_ff   <= in_lo_y;
      lo_z_ff   <= in_lo_z;
      hi_x_ff   <= in_hi_x;
      hi_y_ff   <= in_hi_y;
      hi_z_ff   <= in_hi_z;
      radius_ff <= in_radius;
   end

   // sum and test against zero
   assign dist_sum = SUM_BITS'(prod_x_ff) + SUM_BITS'(prod_y_ff) + SUM_BITS'(prod_z_ff)
                   + SUM_BITS'(bias_ff);
   assign reject = dist_sum[SUM_BITS-1] | (dist_sum == '0);

   always_comb begin
      ctl_b_in         = ctl_a_ff;
      ctl_b_in.visible = ctl_a_ff.visible & ~reject;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_b_ff <= '0;
      end else begin
         ctl_b_ff <= ctl_b_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_x_b_ff   <= lo_x_ff;
      lo_y_b_ff   <= lo_y_ff;
      lo_z_b_ff   <= lo_z_ff;
      hi_x_b_ff   <= hi_x_ff;
      hi_y_b_ff   <= hi_y_ff;
      hi_z_b_ff   <= hi_z_ff;
      radius_b_ff <= radius_ff;
   end

   assign out_ctl    = ctl_b_ff;
   assign out_lo_x   = lo_x_b_ff;
   assign out_lo_y   = lo_y_b_ff;
   assign out_lo_z   = lo_z_b_ff;
   assign out_hi_x   = hi_x_b_ff;
   assign out_hi_y   = hi_y_b_ff;
   assign out_hi_z   = hi_z_b_ff;
   assign out_radius = radius_b_ff;

endmodule

/* rtl/core/frustum_plane_cull_test_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_plane_cull_test_top
// Culls points, spheres, boxes and cubes against six frustum planes.
//
// channel   ports                          transfer
// request   start, busy, req_*             start & !busy
// result    rsp_valid, rsp_visible         one cycle strobe
// config    psel, penable, pwrite, paddr,  access phase, pready tied high
//           pwdata, prdata, pready
//
// One transaction per clock; busy never rises.
// The chain has one entry stage expanding cubes, then two stages
// (multiply, sum and compare) in each of the six plane cells.
// Synchronous reset clears the chain's valid flags and the planes to zero.
// The result cannot be stalled, so nothing holds back the chain.
// ----------------------------------------------------------------------------
module frustum_plane_cull_test_top #(
   parameter int COORD_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_action,
   input  logic signed [COORD_BITS-1:0]         req_min_x,
   input  logic signed [COORD_BITS-1:0]         req_min_y,
   input  logic signed [COORD_BITS-1:0]         req_min_z,
   input  logic signed [COORD_BITS-1:0]         req_max_x,
   input  logic signed [COORD_BITS-1:0]         req_max_y,
   input  logic signed [COORD_BITS-1:0]         req_max_z,
   input  logic [COORD_BITS-2:0]                req_radius,
   output logic                                 rsp_valid,
   output logic                                 rsp_visible,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [fpc_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [fpc_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [fpc_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                 pready
);
   import fpc_pkg::*;

   localparam int CW = COORD_BITS + 1;

   plane_type            planes [NUM_PLANES];
   ctl_type              ctl_chain [NUM_PLANES+1];
   logic signed [CW-1:0] lo_x_chain [NUM_PLANES+1];
   logic signed [CW-1:0] lo_y_chain [NUM_PLANES+1];
   logic signed [CW-1:0] lo_z_chain [NUM_PLANES+1];
   logic signed [CW-1:0] hi_x_chain [NUM_PLANES+1];
   logic signed [CW-1:0] hi_y_chain [NUM_PLANES+1];
   logic signed [CW-1:0] hi_z_chain [NUM_PLANES+1];
   logic [COORD_BITS-2:0] rad_chain [NUM_PLANES+1];

   ctl_type              ctl_in, ctl_ff;
   logic signed [CW-1:0] lo_x_in, lo_y_in, lo_z_in, hi_x_in, hi_y_in, hi_z_in;
   logic signed [CW-1:0] lo_x_ff, lo_y_ff, lo_z_ff, hi_x_ff, hi_y_ff, hi_z_ff;
   logic [COORD_BITS-2:0] radius_ff;
   logic signed [CW-1:0] rad_ext;

   assign busy = 1'b0;

   fpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .planes  (planes)
   );

   // entry stage: widen coordinates, expand cubes to boxes
   assign rad_ext = $signed({2'b00, req_radius});

   always_comb begin
      ctl_in.valid   = start & ~busy;
      ctl_in.visible = 1'b1;
      ctl_in.action  = action_type'(req_action);
      lo_x_in = CW'(req_min_x);
      lo_y_in = CW'(req_min_y);
      lo_z_in = CW'(req_min_z);
      hi_x_in = CW'(req_max_x);
      hi_y_in = CW'(req_max_y);
      hi_z_in = CW'(req_max_z);
      if (ctl_in.action == ACT_CUBE) begin
         lo_x_in = CW'(req_min_x) - rad_ext;
         lo_y_in = CW'(req_min_y) - rad_ext;
         lo_z_in = CW'(req_min_z) - rad_ext;
         hi_x_in = CW'(req_min_x) + rad_ext;
         hi_y_in = CW'(req_min_y) + rad_ext;
         hi_z_in = CW'(req_min_z) + rad_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_x_ff   <= lo_x_in;
      lo_y_ff   <= lo_y_in;
      lo_z_ff   <= lo_z_in;
      hi_x_ff   <= hi_x_in;
      hi_y_ff   <= hi_y_in;
      hi_z_ff   <= hi_z_in;
      radius_ff <= req_radius;
   end

   assign ctl_chain[0]  = ctl_ff;
   assign lo_x_chain[0] = lo_x_ff;
   assign lo_y_chain[0] = lo_y_ff;
   assign lo_z_chain[0] = lo_z_ff;
   assign hi_x_chain[0] = hi_x_ff;
   assign hi_y_chain[0] = hi_y_ff;
   assign hi_z_chain[0] = hi_z_ff;
   assign rad_chain[0]  = radius_ff;

   // row of plane cells
   for (genvar i = 0; i < NUM_PLANES; i++) begin : g_cell
      fpc_cell #(
         .COORD_BITS (COORD_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .plane      (planes[i]),
         .in_ctl     (ctl_chain[i]),
         .in_lo_x    (lo_x_chain[i]),
         .in_lo_y    (lo_y_chain[i]),
         .in_lo_z    (lo_z_chain[i]),
         .in_hi_x    (hi_x_chain[i]),
         .in_hi_y    (hi_y_chain[i]),
         .in_hi_z    (hi_z_chain[i]),
         .in_radius  (rad_chain[i]),
         .out_ctl    (ctl_chain[i+1]),
         .out_lo_x   (lo_x_chain[i+1]),
         .out_lo_y   (lo_y_chain[i+1]),
         .out_lo_z   (lo_z_chain[i+1]),
         .out_hi_x   (hi_x_chain[i+1]),
         .out_hi_y   (hi_y_chain[i+1]),
         .out_hi_z   (hi_z_chain[i+1]),
         .out_radius (rad_chain[i+1])
      );
   end

   // result strobe straight from the last cell
   assign rsp_valid   = ctl_chain[NUM_PLANES].valid;
   assign rsp_visible = ctl_chain[NUM_PLANES].visible;

endmodule

/* rtl/core/fpc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_checker
// Port level checks on the request, result and config strobes of the cull block.
// ----------------------------------------------------------------------------
module fpc_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic psel,
   input logic penable,
   input logic pready
);
   import fpc_pkg::*;

   // the chain never refuses a transaction
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised");

   // every accepted transaction comes out after the fixed latency
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("result missing");

   // no result without a transaction accepted the latency before
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("unexpected result");

   // access phase always completes at once
   a_ready: assert property (@(posedge clock) disable iff (reset)
      (psel && penable) |-> pready)
      else $error("pready low in access phase");

endmodule

bind frustum_plane_cull_test_top fpc_checker u_fpc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .psel      (psel),
   .penable   (penable),
   .pready    (pready)
);

/* tb/tb_frustum_plane_cull_test_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frustum_plane_cull_test_top
// Self-checking bench for the frustum plane cull test block.
//
// Loads six planes over the APB-style port while the pipeline is empty, sends
// points, spheres, boxes and cubes, and predicts each visible flag with an
// exact 64-bit integer model of the plane distances. Every result strobe is
// checked in order against the oldest prediction. Directed edge cases on
// reset, boundary and extreme planes come first, then randomised traffic
// over several plane settings with random idle gaps on the request side.
// ----------------------------------------------------------------------------
module tb_frustum_plane_cull_test_top;

   import fpc_pkg::*;

   localparam int COORD_BITS = 24;
   localparam int RAD_BITS   = COORD_BITS - 1;
   localparam int COORD_MAX  = (1 << (COORD_BITS - 1)) - 1;
   localparam int COORD_MIN  = -(1 << (COORD_BITS - 1));
   localparam int RADIUS_MAX = (1 << (COORD_BITS - 1)) - 1;
   localparam int D_MAX      = (1 << 27) - 1;
   localparam int D_MIN      = -(1 << 27);
   localparam int ITEMS_PER_PHASE = 88;
   localparam int NUM_PHASES = 6;

   // register index of each plane
   typedef enum logic [2:0] {
      PLANE_LEFT   = 3'd0,
      PLANE_RIGHT  = 3'd1,
      PLANE_BOTTOM = 3'd2,
      PLANE_TOP    = 3'd3,
      PLANE_NEAR   = 3'd4,
      PLANE_FAR    = 3'd5
   } plane_sel_type;

   // kind of plane set used by a random phase
   typedef enum logic [1:0] {
      SET_FRUSTUM = 2'd0,
      SET_RAW     = 2'd1,
      SET_EXTREME = 2'd2
   } plane_set_type;

   // one primitive as presented on the request ports
   typedef struct packed {
      action_type                   act;
      logic signed [COORD_BITS-1:0] min_x;
      logic signed [COORD_BITS-1:0] min_y;
      logic signed [COORD_BITS-1:0] min_z;
      logic signed [COORD_BITS-1:0] max_x;
      logic signed [COORD_BITS-1:0] max_y;
      logic signed [COORD_BITS-1:0] max_z;
      logic [COORD_BITS-2:0]        radius;
   } prim_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [1:0]                   req_action = '0;
   logic signed [COORD_BITS-1:0] req_min_x = '0;
   logic signed [COORD_BITS-1:0] req_min_y = '0;
   logic signed [COORD_BITS-1:0] req_min_z = '0;
   logic signed [COORD_BITS-1:0] req_max_x = '0;
   logic signed [COORD_BITS-1:0] req_max_y = '0;
   logic signed [COORD_BITS-1:0] req_max_z = '0;
   logic [COORD_BITS-2:0]        req_radius = '0;
   logic                         rsp_valid;
   logic                         rsp_visible;
   logic                         psel = 1'b0;
   logic                         penable = 1'b0;
   logic                         pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]     paddr = '0;
   logic [CSR_DATA_BITS-1:0]     pwdata = '0;
   logic [CSR_DATA_BITS-1:0]     prdata;
   logic                         pready;

   // plane registers as the block should hold them
   plane_type plane_cfg [NUM_PLANES];
   // predicted visible flags, oldest first
   logic      visible_expect_q [$];
   logic      want_visible;
   bit        no_gaps = 1'b0;
   int        n_sent = 0;
   int        n_checked = 0;
   int        n_visible = 0;
   int        n_errors = 0;
   int        n_plane_sets = 0;

   frustum_plane_cull_test_top #(
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_min_x(req_min_x),
      .req_min_y(req_min_y),
      .req_min_z(req_min_z),
      .req_max_x(req_max_x),
      .req_max_y(req_max_y),
      .req_max_z(req_max_z),
      .req_radius(req_radius),
      .rsp_valid(rsp_valid),
      .rsp_visible(rsp_visible),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   // clock
   always #1 clock = ~clock;

   // signed distance scaled to Q.18
   function automatic longint plane_dist(plane_type pl, longint x, longint y, longint z);
      return longint'(pl.a) * x + longint'(pl.b) * y + longint'(pl.c) * z
           + longint'(pl.d) * 1024;
   endfunction

   // visible flag for one primitive against the current planes
   function automatic logic predict_visible(prim_type p);
      longint lo [3];
      longint hi [3];
      longint r;
      longint centre;
      logic   vis;
      bit     all_behind;
      r = longint'(p.radius);
      lo[0] = longint'(p.min_x);
      lo[1] = longint'(p.min_y);
      lo[2] = longint'(p.min_z);
      hi[0] = longint'(p.max_x);
      hi[1] = longint'(p.max_y);
      hi[2] = longint'(p.max_z);
      // cube becomes a box one bit wider than a coordinate
      if (p.act == ACT_CUBE) begin
         for (int j = 0; j < 3; j++) begin
            centre = lo[j];
            lo[j] = centre - r;
            hi[j] = centre + r;
         end
      end
      vis = 1'b1;
      for (int i = 0; i < NUM_PLANES; i++) begin
         case (p.act)
            ACT_POINT: begin
               if (plane_dist(plane_cfg[i], lo[0], lo[1], lo[2]) <= 0) vis = 1'b0;
            end
            ACT_SPHERE: begin
               if (plane_dist(plane_cfg[i], lo[0], lo[1], lo[2]) <= -(r * 1024))
                  vis = 1'b0;
            end
            default: begin
               all_behind = 1'b1;
               for (int k = 0; k < 8; k++) begin
                  if (plane_dist(plane_cfg[i],
                                 (k & 1) ? hi[0] : lo[0],
                                 (k & 2) ? hi[1] : lo[1],
                                 (k & 4) ? hi[2] : lo[2]) > 0)
                     all_behind = 1'b0;
               end
               if (all_behind) vis = 1'b0;
            end
         endcase
      end
      return vis;
   endfunction

   function automatic prim_type make_prim(action_type act, int x0, int y0, int z0,
                                          int x1, int y1, int z1, int rad);
      prim_type p;
      p.act = act;
      p.min_x = COORD_BITS'(x0);
      p.min_y = COORD_BITS'(y0);
      p.min_z = COORD_BITS'(z0);
      p.max_x = COORD_BITS'(x1);
      p.max_y = COORD_BITS'(y1);
      p.max_z = COORD_BITS'(z1);
      p.radius = RAD_BITS'(rad);
      return p;
   endfunction

   function automatic logic signed [COORD_BITS-1:0] rand_coord(int span);
      logic signed [COORD_BITS-1:0] v;
      v = COORD_BITS'(int'($urandom_range(0, 2 * span)) - span);
      return v;
   endfunction

   // random primitive; a share of fully random bit patterns in every phase
   function automatic prim_type random_prim(int span, bit wild);
      prim_type p;
      int       ext;
      p.act = action_type'($urandom_range(0, 3));
      if (wild || $urandom_range(0, 9) == 0) begin
         p.min_x = COORD_BITS'($urandom());
         p.min_y = COORD_BITS'($urandom());
         p.min_z = COORD_BITS'($urandom());
         p.max_x = COORD_BITS'($urandom());
         p.max_y = COORD_BITS'($urandom());
         p.max_z = COORD_BITS'($urandom());
         p.radius = RAD_BITS'($urandom());
         return p;
      end
      p.min_x = rand_coord(span);
      p.min_y = rand_coord(span);
      p.min_z = rand_coord(span);
      ext = $urandom_range(0, span / 2);
      // box max mostly above min, sometimes inverted or unrelated
      case ($urandom_range(0, 5))
         0: begin
            p.max_x = rand_coord(span);
            p.max_y = rand_coord(span);
            p.max_z = rand_coord(span);
         end
         1: begin
            p.max_x = COORD_BITS'(p.min_x - ext);
            p.max_y = COORD_BITS'(p.min_y - int'($urandom_range(0, ext)));
            p.max_z = COORD_BITS'(p.min_z - int'($urandom_range(0, ext)));
         end
         default: begin
            p.max_x = COORD_BITS'(p.min_x + ext);
            p.max_y = COORD_BITS'(p.min_y + int'($urandom_range(0, ext)));
            p.max_z = COORD_BITS'(p.min_z + int'($urandom_range(0, ext)));
         end
      endcase
      if ($urandom_range(0, 7) == 0) p.radius = RAD_BITS'($urandom());
      else p.radius = RAD_BITS'($urandom_range(0, span / 4));
      return p;
   endfunction

   // plane facing inwards along one axis, optionally tilted at random
   function automatic plane_type box_plane(int idx, int half_q8, bit tilt);
      plane_type pl;
      int        nrm [3];
      int        axis;
      axis = idx / 2;
      for (int j = 0; j < 3; j++) nrm[j] = tilt ? int'($urandom_range(0, 300)) - 150 : 0;
      nrm[axis] = (idx % 2 == 0) ? 1024 : -1024;
      if (tilt) nrm[axis] = nrm[axis] + int'($urandom_range(0, 400)) - 200;
      pl.a = 12'(nrm[0]);
      pl.b = 12'(nrm[1]);
      pl.c = 12'(nrm[2]);
      pl.d = 28'(tilt ? half_q8 + int'($urandom_range(0, 2000)) - 1000 : half_q8);
      return pl;
   endfunction

   function automatic plane_type extreme_plane();
      plane_type pl;
      pl.a = 12'($urandom_range(0, 1) ? 2047 : -2048);
      pl.b = 12'($urandom_range(0, 1) ? 2047 : -2048);
      pl.c = 12'($urandom_range(0, 1) ? 2047 : -2048);
      pl.d = 28'($urandom_range(0, 1) ? D_MAX : D_MIN);
      return pl;
   endfunction

   function automatic int idle_gap();
      int roll;
      if (no_gaps) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   // one register write: setup cycle, access cycle, then a quiet cycle
   task automatic csr_write_plane(input plane_sel_type sel, input plane_type value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_BITS'(sel) << 3;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      plane_cfg[sel] = value;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_planes(input plane_set_type kind, input int half_q8, input bit tilt);
      plane_type pl;
      for (int i = 0; i < NUM_PLANES; i++) begin
         case (kind)
            SET_RAW:     pl = {$urandom(), $urandom()};
            SET_EXTREME: pl = extreme_plane();
            default:     pl = box_plane(i, half_q8, tilt);
         endcase
         csr_write_plane(plane_sel_type'(i), pl);
      end
      n_plane_sets++;
   endtask

   // send one transaction, then idle for a random gap
   task automatic send_item(input prim_type p);
      int gap;
      req_action <= p.act;
      req_min_x <= p.min_x;
      req_min_y <= p.min_y;
      req_min_z <= p.min_z;
      req_max_x <= p.max_x;
      req_max_y <= p.max_y;
      req_max_z <= p.max_z;
      req_radius <= p.radius;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      visible_expect_q.push_back(predict_visible(p));
      n_sent++;
      gap = idle_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending and let every outstanding result come back
   task automatic wait_drained();
      start <= 1'b0;
      while (visible_expect_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // planes cleared by reset: points, boxes, cubes and zero spheres are culled
   task automatic test_zero_planes();
      send_item(make_prim(ACT_POINT, 0, 0, 0, $urandom(), $urandom(), $urandom(),
                          $urandom()));
      send_item(make_prim(ACT_SPHERE, 1234, -5678, 99, $urandom(), $urandom(),
                          $urandom(), 0));
      send_item(make_prim(ACT_SPHERE, 1234, -5678, 99, 0, 0, 0, 1));
      send_item(make_prim(ACT_BOX, COORD_MIN, COORD_MIN, COORD_MIN,
                          COORD_MAX, COORD_MAX, COORD_MAX, $urandom()));
      send_item(make_prim(ACT_CUBE, 0, 0, 0, $urandom(), $urandom(), $urandom(), 5));
      wait_drained();
   endtask

   // axis-aligned frustum of half-size 100.0: boundaries and corner cases
   task automatic test_edge_cases();
      int h;
      h = 100 * 256;
      load_planes(SET_FRUSTUM, h, 1'b0);
      // point on, just inside and far outside a plane
      send_item(make_prim(ACT_POINT, 0, 0, 0, COORD_MAX, COORD_MIN, 7, RADIUS_MAX));
      send_item(make_prim(ACT_POINT, -h, 0, 0, 0, 0, 0, 0));
      send_item(make_prim(ACT_POINT, -h + 1, h - 1, 0, 0, 0, 0, 0));
      send_item(make_prim(ACT_POINT, COORD_MAX, 0, 0, 0, 0, 0, 0));
      send_item(make_prim(ACT_POINT, 0, 0, COORD_MIN, 0, 0, 0, 0));
      // sphere touching from outside, just reaching in, huge and zero radius
      send_item(make_prim(ACT_SPHERE, -h - 256, 0, 0, 0, 0, 0, 256));
      send_item(make_prim(ACT_SPHERE, -h - 256, 0, 0, 0, 0, 0, 257));
      send_item(make_prim(ACT_SPHERE, COORD_MIN, COORD_MAX, COORD_MIN, 0, 0, 0,
                          RADIUS_MAX));
      send_item(make_prim(ACT_SPHERE, 0, 0, 0, COORD_MIN, COORD_MAX, 3, 0));
      // box straddling, wholly behind, touching, inverted and full range
      send_item(make_prim(ACT_BOX, -30000, -10, -10, -20000, 10, 10, RADIUS_MAX));
      send_item(make_prim(ACT_BOX, -40000, -10, -10, -30000, 10, 10, 0));
      send_item(make_prim(ACT_BOX, -40000, -10, -10, -h, 10, 10, 0));
      send_item(make_prim(ACT_BOX, 1000, 1000, 1000, -1000, -1000, -1000, 0));
      send_item(make_prim(ACT_BOX, -30000, 0, 0, -40000, 0, 0, 0));
      send_item(make_prim(ACT_BOX, COORD_MIN, COORD_MIN, COORD_MIN,
                          COORD_MAX, COORD_MAX, COORD_MAX, 0));
      // cube just touching, just reaching in, and at the coordinate extremes
      send_item(make_prim(ACT_CUBE, -h - 1000, 0, 0, COORD_MAX, COORD_MIN, 0, 1000));
      send_item(make_prim(ACT_CUBE, -h - 1000, 0, 0, 0, 0, 0, 1001));
      send_item(make_prim(ACT_CUBE, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0,
                          RADIUS_MAX));
      send_item(make_prim(ACT_CUBE, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0,
                          RADIUS_MAX));
      wait_drained();
   endtask

   // largest coefficients and offsets against extreme coordinates
   task automatic test_extreme_planes();
      load_planes(SET_EXTREME, 0, 1'b0);
      send_item(make_prim(ACT_POINT, COORD_MIN, COORD_MAX, COORD_MIN, 0, 0, 0, 0));
      send_item(make_prim(ACT_SPHERE, COORD_MAX, COORD_MIN, COORD_MAX, 0, 0, 0,
                          RADIUS_MAX));
      send_item(make_prim(ACT_BOX, COORD_MIN, COORD_MIN, COORD_MIN,
                          COORD_MAX, COORD_MAX, COORD_MAX, 0));
      send_item(make_prim(ACT_CUBE, COORD_MAX, COORD_MIN, COORD_MAX, 0, 0, 0,
                          RADIUS_MAX));
      wait_drained();
   endtask

   // random traffic over several plane settings
   task automatic test_random_traffic();
      plane_set_type kind;
      int            half_q8;
      int            span;
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         kind = (ph == 2) ? SET_RAW : (ph == 4) ? SET_EXTREME : SET_FRUSTUM;
         half_q8 = $urandom_range(20, 600) * 256;
         span = (kind == SET_FRUSTUM) ? half_q8 + half_q8 / 2 : COORD_MAX;
         load_planes(kind, half_q8, 1'b1);
         // one phase runs back to back with no idle cycles
         no_gaps = (ph == 1);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // sender holds off mid-phase until the pipeline is empty
            if (ph == 3 && n == ITEMS_PER_PHASE / 2) wait_drained();
            send_item(random_prim(span, kind == SET_RAW));
         end
         no_gaps = 1'b0;
         wait_drained();
      end
   endtask

   // compare each result strobe with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (visible_expect_q.size() == 0) begin
            n_errors++;
            $display("%0t: unexpected result: expected none, actual visible=%0b",
                     $time, rsp_visible);
         end else begin
            want_visible = visible_expect_q.pop_front();
            n_checked++;
            if (rsp_visible === 1'b1) n_visible++;
            if (rsp_visible !== want_visible) begin
               n_errors++;
               $display("%0t: visible mismatch on transaction %0d: expected %0b, actual %0b",
                        $time, n_checked, want_visible, rsp_visible);
            end
         end
      end
   end

   // stimulus sequence
   initial begin
      for (int i = 0; i < NUM_PLANES; i++) plane_cfg[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_zero_planes();
      test_edge_cases();
      test_extreme_planes();
      test_random_traffic();
      wait_drained();
      repeat (LATENCY + 4) @(posedge clock);
      $display("covered %0d transactions of points, spheres, boxes and cubes over %0d plane settings",
               n_sent, n_plane_sets);
      $display("checked %0d results: %0d visible, %0d culled, %0d mismatches",
               n_checked, n_visible, n_checked - n_visible, n_errors);
      if (n_errors == 0 && visible_expect_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #200000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/fpc_pkg.sv
rtl/core/fpc_csr.sv
rtl/core/fpc_cell.sv
rtl/core/frustum_plane_cull_test_top.sv
rtl/core/fpc_checker.sv
tb/tb_frustum_plane_cull_test_top.sv
